[sv/wcg_pkg.sv]
// wcg_pkg: shared types and codes of the wave channel generator
// no dependencies; imported by every module of the block

package wcg_pkg;

    // operation codes carried in the low bits of s_tuser
    localparam logic [1:0] OP_CTRL  = 2'd0;
    localparam logic [1:0] OP_TABLE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // control register selectors
    localparam logic [2:0] REG_ONOFF = 3'd0;
    localparam logic [2:0] REG_LEN   = 3'd1;
    localparam logic [2:0] REG_LEVEL = 3'd2;
    localparam logic [2:0] REG_FLO   = 3'd3;
    localparam logic [2:0] REG_FHI   = 3'd4;
    localparam logic [2:0] REG_POWER = 3'd5;

    // fixed widths
    localparam int FREQ_W  = 11;
    localparam int TIMER_W = 13;
    localparam int CD_W    = 16;
    localparam logic [11:0] FREQ_FULL = 12'd2048;
    localparam logic [7:0]  LCOUNT_MAX = 8'd255;

    // per-tick information handed from the control stage to the output stage
    typedef struct packed {
        logic       emit;        // a result leaves on this tick
        logic       load;        // the timer expired, take a new nibble
        logic       odd;         // low nibble when set, high nibble otherwise
        logic       channel_on;
        logic       playing;
    } tick_info_t;

    // wave table access issued by the control stage
    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [3:0] raddr;
    } table_req_t;

endpackage

[sv/wcg_table.sv]
// wcg_table: 16 x 8 wave table, one write and one registered read per cycle
// depends on wcg_pkg for the access request struct

module wcg_table (
    input  logic                clk,
    input  logic                rst_n,
    input  wcg_pkg::table_req_t req,
    output logic [7:0]          rdata
);
    import wcg_pkg::*;

    logic [7:0]  mem [16];
    logic [15:0] valid_reg;
    logic [7:0]  rdata_reg;
    logic        rvalid_reg;

    // written entries; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    // storage and registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg  <= mem[req.raddr];
            rvalid_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'd0;

endmodule

[sv/wcg_ctrl.sv]
// wcg_ctrl: channel registers, timers and countdowns; issues the table access
// depends on wcg_pkg; feeds wcg_table and wcg_out

module wcg_ctrl #(
    parameter int STEP_CYCLES       = 4,
    parameter int DOWNSAMPLE_CYCLES = 96,
    parameter int FRAME_SEQ_CYCLES  = 8192,
    parameter int WAVE_NIBBLES      = 32,
    parameter int SEQ_STEPS         = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                adv,
    input  logic [1:0]          op,
    input  logic [2:0]          reg_select,
    input  logic [3:0]          table_addr,
    input  logic [7:0]          data,
    output wcg_pkg::table_req_t req,
    output logic                s2_valid,
    output wcg_pkg::tick_info_t s2_info
);
    import wcg_pkg::*;

    localparam int POS_W = (WAVE_NIBBLES > 2) ? $clog2(WAVE_NIBBLES) : 1;
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(WAVE_NIBBLES - 1);
    localparam logic [2:0]         SEQ_LAST  = 3'(SEQ_STEPS - 1);
    localparam logic [TIMER_W-1:0] STEP_T    = TIMER_W'(STEP_CYCLES);
    localparam logic [CD_W-1:0]    STEP_CD   = CD_W'(STEP_CYCLES);
    localparam logic [CD_W:0]      STEP_SUM  = (CD_W+1)'(STEP_CYCLES);
    localparam logic [CD_W:0]      DS_PERIOD = (CD_W+1)'(DOWNSAMPLE_CYCLES);
    localparam logic [CD_W:0]      FS_PERIOD = (CD_W+1)'(FRAME_SEQ_CYCLES);

    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [6:0]         limit_reg, limit_next;
    logic [7:0]         lcount_reg, lcount_next;
    logic               len_en_reg, len_en_next;
    logic               restart_reg, restart_next;
    logic               play_reg, play_next;
    logic               on_reg, on_next;
    logic               power_reg, power_next;
    logic [2:0]         seq_reg, seq_next;
    logic [CD_W-1:0]    ds_cd_reg, ds_cd_next;
    logic [CD_W-1:0]    fs_cd_reg, fs_cd_next;
    logic               s2_valid_reg, s2_valid_next;
    tick_info_t         s2_info_reg, s2_info_next;

    // tick arithmetic
    logic               len_hit;
    logic [7:0]         lcount_chk;
    logic [TIMER_W-1:0] timer_dec;
    logic               expire;
    logic [POS_W-1:0]   pos_start;
    logic [POS_W-1:0]   pos_tick;
    logic [5:0]         pos_wide;
    logic               ds_fire, fs_fire;
    logic [CD_W:0]      ds_sum, fs_sum;
    logic [CD_W-1:0]    ds_new, fs_new;
    logic [11:0]        reload_half;

    always_comb
    begin
        len_hit     = len_en_reg && (lcount_reg >= {1'b0, limit_reg});
        lcount_chk  = len_hit ? 8'd0 : lcount_reg;
        timer_dec   = (timer_reg >= STEP_T) ? (timer_reg - STEP_T) : '0;
        expire      = (timer_dec == '0);
        pos_start   = restart_reg ? '0 : pos_reg;
        pos_tick    = pos_start;
        if (expire)
        begin
            pos_tick = (pos_start == POS_LAST) ? '0 : (pos_start + POS_W'(1));
        end
        pos_wide    = 6'(pos_tick);
        reload_half = FREQ_FULL - {1'b0, freq_reg};

        // downsample countdown
        ds_fire = (ds_cd_reg <= STEP_CD);
        ds_sum  = {1'b0, ds_cd_reg} + DS_PERIOD;
        if (ds_fire)
        begin
            ds_new = (ds_sum > STEP_SUM) ? CD_W'(ds_sum - STEP_SUM) : '0;
        end
        else
        begin
            ds_new = ds_cd_reg - STEP_CD;
        end

        // frame sequencer countdown
        fs_fire = (fs_cd_reg <= STEP_CD);
        fs_sum  = {1'b0, fs_cd_reg} + FS_PERIOD;
        if (fs_fire)
        begin
            fs_new = (fs_sum > STEP_SUM) ? CD_W'(fs_sum - STEP_SUM) : '0;
        end
        else
        begin
            fs_new = fs_cd_reg - STEP_CD;
        end
    end

    // next state per accepted transaction
    always_comb
    begin
        freq_next     = freq_reg;
        timer_next    = timer_reg;
        pos_next      = pos_reg;
        limit_next    = limit_reg;
        lcount_next   = lcount_reg;
        len_en_next   = len_en_reg;
        restart_next  = restart_reg;
        play_next     = play_reg;
        on_next       = on_reg;
        power_next    = power_reg;
        seq_next      = seq_reg;
        ds_cd_next    = ds_cd_reg;
        fs_cd_next    = fs_cd_reg;
        s2_valid_next = s2_valid_reg;
        s2_info_next  = s2_info_reg;
        req.we        = 1'b0;
        req.waddr     = table_addr;
        req.wdata     = data;
        req.re        = 1'b0;
        req.raddr     = pos_wide[4:1];

        if (adv)
        begin
            s2_valid_next = accept && (op == OP_TICK);
        end

        if (accept)
        begin
            case (op)
                OP_CTRL:
                begin
                    case (reg_select)
                        REG_ONOFF: play_next  = data[7];
                        REG_LEN:   limit_next = data[6:0];
                        REG_FLO:   freq_next  = {freq_reg[10:8], data};
                        REG_FHI:
                        begin
                            restart_next = data[7];
                            len_en_next  = data[6];
                            freq_next    = {data[2:0], freq_reg[7:0]};
                        end
                        REG_POWER:
                        begin
                            if (data[7] && !power_reg)
                            begin
                                seq_next = 3'd0;
                            end
                            else if (!data[7] && power_reg)
                            begin
                                play_next    = 1'b0;
                                limit_next   = 7'd0;
                                freq_next    = '0;
                                len_en_next  = 1'b0;
                                restart_next = 1'b0;
                                on_next      = 1'b0;
                            end
                            power_next = data[7];
                        end
                        default: ;
                    endcase
                end
                OP_TABLE:
                begin
                    req.we = 1'b1;
                end
                OP_TICK:
                begin
                    // length check, restart, period timer
                    if (len_hit)
                    begin
                        play_next = 1'b0;
                    end
                    if (restart_reg)
                    begin
                        restart_next = 1'b0;
                        on_next      = 1'b1;
                    end
                    timer_next = expire ? TIMER_W'({reload_half, 1'b0}) : timer_dec;
                    pos_next   = pos_tick;
                    req.re     = 1'b1;

                    // countdowns, length counter and sequencer
                    ds_cd_next  = ds_new;
                    fs_cd_next  = fs_new;
                    lcount_next = lcount_chk;
                    if (fs_fire)
                    begin
                        if (lcount_chk != LCOUNT_MAX)
                        begin
                            lcount_next = lcount_chk + 8'd1;
                        end
                        seq_next = (seq_reg == SEQ_LAST) ? 3'd0 : (seq_reg + 3'd1);
                    end

                    s2_info_next.emit       = ds_fire;
                    s2_info_next.load       = expire;
                    s2_info_next.odd        = pos_tick[0];
                    s2_info_next.channel_on = restart_reg | on_reg;
                    s2_info_next.playing    = play_reg & ~len_hit;
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg     <= '0;
            timer_reg    <= '0;
            pos_reg      <= '0;
            limit_reg    <= '0;
            lcount_reg   <= '0;
            len_en_reg   <= 1'b0;
            restart_reg  <= 1'b0;
            play_reg     <= 1'b0;
            on_reg       <= 1'b0;
            power_reg    <= 1'b0;
            seq_reg      <= '0;
            ds_cd_reg    <= '0;
            fs_cd_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            freq_reg     <= freq_next;
            timer_reg    <= timer_next;
            pos_reg      <= pos_next;
            limit_reg    <= limit_next;
            lcount_reg   <= lcount_next;
            len_en_reg   <= len_en_next;
            restart_reg  <= restart_next;
            play_reg     <= play_next;
            on_reg       <= on_next;
            power_reg    <= power_next;
            seq_reg      <= seq_next;
            ds_cd_reg    <= ds_cd_next;
            fs_cd_reg    <= fs_cd_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s2_info_reg <= s2_info_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2_info  = s2_info_reg;

endmodule

[sv/wcg_out.sv]
// wcg_out: sample latch fed by the table read, and the result register
// depends on wcg_pkg; takes the stage from wcg_ctrl and data from wcg_table

module wcg_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s2_valid,
    input  wcg_pkg::tick_info_t s2_info,
    input  logic [7:0]          rdata,
    input  logic                m_tready,
    output logic                adv,
    output logic                m_tvalid,
    output logic [7:0]          m_tdata   // [3:0] sample, [4] channel_on, [5] playing
);
    import wcg_pkg::*;

    logic [3:0] latched_reg;
    logic [3:0] sample;
    logic       out_valid_reg, out_valid_next;
    logic [5:0] out_data_reg;

    // pipeline moves unless a result is blocked behind a full output register
    assign adv = !(s2_valid && s2_info.emit && out_valid_reg && !m_tready);

    // nibble selection
    always_comb
    begin
        if (s2_info.load)
        begin
            sample = s2_info.odd ? rdata[3:0] : rdata[7:4];
        end
        else
        begin
            sample = latched_reg;
        end
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (adv && s2_valid && s2_info.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv && s2_valid)
            begin
                latched_reg <= sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid && s2_info.emit)
        begin
            out_data_reg <= {s2_info.playing, s2_info.channel_on, sample};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

[sv/wave_channel_generator_core.sv]
// Wave channel generator: control writes, wave table writes and ticks arrive as
// transactions on the slave side; a tick at a downsample instant returns one
// result on the master side. One transaction is taken every cycle unless the
// slave side stalls. A result is formed in steps: the first updates the channel
// registers and reads the wave table byte, the second latches the nibble from
// the table's registered read port into the result register. The slave side
// stalls only while a result waits behind an unread one. The wave table is a
// 16-byte memory whose entries read as zero until written; no clearing pass.
// Depends on wcg_pkg, wcg_ctrl, wcg_table and wcg_out.

module wave_channel_generator_core #(
    parameter int STEP_CYCLES       = 4,
    parameter int DOWNSAMPLE_CYCLES = 96,
    parameter int FRAME_SEQ_CYCLES  = 8192,
    parameter int WAVE_NIBBLES      = 32,
    parameter int SEQ_STEPS         = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [4:0]  s_tuser,   // [1:0] op, [4:2] reg_select
    input  logic [15:0] s_tdata,   // [3:0] table_addr, [11:4] data, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [3:0] sample, [4] channel_on, [5] playing, [7:6] zero
);
    import wcg_pkg::*;

    logic       adv;
    logic       accept;
    table_req_t req;
    logic [7:0] rdata;
    logic       s2_valid;
    tick_info_t s2_info;

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // channel registers and timers
    wcg_ctrl #(
        .STEP_CYCLES       (STEP_CYCLES),
        .DOWNSAMPLE_CYCLES (DOWNSAMPLE_CYCLES),
        .FRAME_SEQ_CYCLES  (FRAME_SEQ_CYCLES),
        .WAVE_NIBBLES      (WAVE_NIBBLES),
        .SEQ_STEPS         (SEQ_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .adv        (adv),
        .op         (s_tuser[1:0]),
        .reg_select (s_tuser[4:2]),
        .table_addr (s_tdata[3:0]),
        .data       (s_tdata[11:4]),
        .req        (req),
        .s2_valid   (s2_valid),
        .s2_info    (s2_info)
    );

    // wave table memory
    wcg_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (rdata)
    );

    // sample latch and result register
    wcg_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid),
        .s2_info  (s2_info),
        .rdata    (rdata),
        .m_tready (m_tready),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

[sv/wcg_chk.sv]
// wcg_chk: port-level checks of the wave channel generator, bound to the top
// depends on wcg_pkg and wave_channel_generator_core

module wcg_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [4:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    import wcg_pkg::*;

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the slave side stalls only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a fresh result follows an accepted tick on the slave side
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[1:0] == OP_TICK), 2))
        else $error("result without a tick");

    // padding bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("result padding not zero");

endmodule

bind wave_channel_generator_core wcg_chk u_wcg_chk (.*);
